>>> design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam int OP_W       = 2;
    localparam int IDX_IN_W   = 10;
    localparam int KEY_IN_W   = 32;
    localparam int POS_W      = 11;
    localparam int CNT_CFG_W  = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register decode on word address paddr[2]
    localparam logic REG_ENTRY_COUNT    = 1'b0;
    localparam logic REG_COMPARE_SIGNED = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_FIND  = 2'd1,
        OP_LOWER = 2'd2,
        OP_UPPER = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [IDX_IN_W-1:0] idx;
        logic                in_range;
        logic [KEY_IN_W-1:0] key;
    } t_req;

endpackage

>>> design/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = sts_pkg::DEF_KEY_WIDTH,
    parameter int DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sts_front #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sts_pkg::OP_W-1:0]      i_operation,
    input  logic [sts_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic [sts_pkg::KEY_IN_W-1:0]  i_key_value,
    output logic                          o_req_valid,
    output sts_pkg::t_req                 o_req,
    input  logic                          i_pop
);
    import sts_pkg::*;

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    t_req       req_in;
    logic [31:0] idx_ext;

    assign o_in_stall  = (r_count == 2'd2);
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_q[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;

    always_comb begin
        idx_ext         = {22'b0, i_entry_index};
        req_in.op       = t_op'(i_operation);
        req_in.idx      = i_entry_index;
        req_in.in_range = (idx_ext < 32'(TABLE_DEPTH));
        req_in.key      = i_key_value;
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

endmodule

>>> design/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// Executes queued requests: table writes and bisection searches over the
// key RAM, one probe per read-compare pair, into a held result register.
// ----------------------------------------------------------------------------
module sts_back #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sts_pkg::CNT_CFG_W-1:0] i_entry_count,
    input  logic                          i_compare_signed,
    input  logic                          i_req_valid,
    input  sts_pkg::t_req                 i_req,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [sts_pkg::POS_W-1:0]     o_position
);
    import sts_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
        logic [CNT_W+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, v};
        return ext[POS_W-1:0];
    endfunction

    t_state               r_state;
    t_state               n_state;
    t_op                  r_op;
    t_op                  n_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic [CNT_W-1:0]     r_b;
    logic [CNT_W-1:0]     n_b;
    logic [CNT_W-1:0]     r_e;
    logic [CNT_W-1:0]     n_e;
    logic [CNT_W-1:0]     r_h;
    logic [CNT_W-1:0]     n_h;
    logic                 r_res_found;
    logic                 n_res_found;
    logic [POS_W-1:0]     r_res_pos;
    logic [POS_W-1:0]     n_res_pos;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_found;
    logic                 n_found;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;

    logic [KEY_WIDTH+KEY_IN_W-1:0] key_ext;
    logic [IDX_W+IDX_IN_W-1:0]     idx_ext;
    logic [31:0]                   cnt_ext;
    logic [CNT_W-1:0]              active;
    logic [CNT_W-1:0]              mid;
    logic [KEY_WIDTH-1:0]          flip;
    logic [KEY_WIDTH-1:0]          ka;
    logic [KEY_WIDTH-1:0]          kb;
    logic                          gt;
    logic                          eq;
    logic                          out_free;

    sts_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (key_ext[KEY_WIDTH-1:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        key_ext = {{KEY_WIDTH{1'b0}}, i_req.key};
        idx_ext = {{IDX_W{1'b0}}, i_req.idx};
        wr_addr = idx_ext[IDX_W-1:0];
        cnt_ext = {21'b0, i_entry_count};
        active  = (cnt_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_ext[CNT_W-1:0];
        mid     = r_b + ((r_e - r_b) >> 1);
        rd_addr = mid[IDX_W-1:0];
        flip                = '0;
        flip[KEY_WIDTH-1]   = i_compare_signed;
        ka      = r_key ^ flip;
        kb      = rd_data ^ flip;
        gt      = (ka > kb);
        eq      = (ka == kb);
        out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.op == OP_WRITE) ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = (r_b < r_e) ? ST_CMP : ST_DONE;
            end
            ST_CMP: begin
                n_state = (r_op == OP_FIND && eq) ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        n_op        = r_op;
        n_key       = r_key;
        n_b         = r_b;
        n_e         = r_e;
        n_h         = r_h;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_pos       = r_pos;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_pop       = 1'b1;
                    n_op        = i_req.op;
                    n_key       = key_ext[KEY_WIDTH-1:0];
                    n_b         = '0;
                    n_e         = active;
                    n_res_found = 1'b0;
                    n_res_pos   = {1'b0, i_req.idx};
                    wr_en       = (i_req.op == OP_WRITE) && i_req.in_range;
                end
            end
            ST_PROBE: begin
                n_h = mid;
                if (!(r_b < r_e)) begin
                    n_res_found = 1'b0;
                    case (r_op)
                        OP_LOWER: n_res_pos = to_pos(r_b);
                        OP_UPPER: n_res_pos = to_pos(r_e);
                        default:  n_res_pos = '0;
                    endcase
                end
            end
            ST_CMP: begin
                case (r_op)
                    OP_FIND: begin
                        if (eq) begin
                            n_res_found = 1'b1;
                            n_res_pos   = to_pos(r_h);
                        end else if (gt) begin
                            n_b = r_h + CNT_W'(1);
                        end else begin
                            n_e = r_h;
                        end
                    end
                    OP_LOWER: begin
                        if (gt) begin
                            n_b = r_h + CNT_W'(1);
                        end else begin
                            n_e = r_h;
                        end
                    end
                    default: begin
                        if (gt || eq) begin
                            n_b = r_h + CNT_W'(1);
                        end else begin
                            n_e = r_h;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_pos       = r_res_pos;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_b         <= n_b;
        r_e         <= n_e;
        r_h         <= n_h;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_found     <= n_found;
        r_pos       <= n_pos;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_pos;

endmodule

>>> design/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted key table with exact find, lower bound and upper bound searches.
//
// Requests enter on i_in_valid / o_in_stall with operation, entry_index and
// key_value; one result per request leaves on o_out_valid / i_out_stall as
// found and position. A write stores the key when its index lies inside the
// table and returns its index; searches bisect the first entry_count (at most
// TABLE_DEPTH) entries of the key RAM. A two-entry queue sits between intake
// and execution, so intake keeps taking requests while a result waits at the
// output. A write passes from the idle state to the done state; a search runs
// P probes, at most ceil(log2(count+1)) (11 for 1024), and an exact find
// that hits goes to the done state straight after its compare.
// Each probe is one registered RAM read then one key compare. Requests are
// executed one at a time: the next one is taken only after the last result
// has moved to the output register.
// While i_out_stall is high the result is held and execution stops once
// the next result is ready; the queue then fills and raises o_in_stall.
// Reset clears the queue, the sequencer, the output valid and both config
// registers; table contents are undefined until written.
// Config: APB, entry_count at 0x0, compare_signed at 0x4.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sts_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sts_pkg::OP_W-1:0]       i_operation,
    input  logic [sts_pkg::IDX_IN_W-1:0]   i_entry_index,
    input  logic [sts_pkg::KEY_IN_W-1:0]   i_key_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic [sts_pkg::POS_W-1:0]      o_position
);
    import sts_pkg::*;

    logic [CNT_CFG_W-1:0] r_entry_count;
    logic                 r_compare_signed;
    logic                 cfg_wr;
    logic                 req_valid;
    t_req                 req;
    logic                 pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_compare_signed <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ENTRY_COUNT:    r_entry_count    <= pwdata[CNT_CFG_W-1:0];
                REG_COMPARE_SIGNED: r_compare_signed <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ENTRY_COUNT:    prdata = {{(APB_DATA_W-CNT_CFG_W){1'b0}}, r_entry_count};
            REG_COMPARE_SIGNED: prdata = {{(APB_DATA_W-1){1'b0}}, r_compare_signed};
            default:            prdata = '0;
        endcase
    end

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_pop         (pop)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry_count    (r_entry_count),
        .i_compare_signed (r_compare_signed),
        .i_req_valid      (req_valid),
        .i_req            (req),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_position       (o_position)
    );

    a_full_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> req_valid)
        else $error("queue full but no request visible");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> req_valid)
        else $error("pop from empty queue");

    a_found_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> ({21'b0, o_position} < 32'(TABLE_DEPTH)))
        else $error("found position outside table");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

>>> bench/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Self-checking bench for the sorted key table search block.
//
// Loads sorted tables through write requests, sweeps entry_count and the
// compare mode over APB, and runs exact find, lower bound and upper bound
// searches against an in-bench bisection model. Every result is compared
// in order with the predicted found flag and position, under random
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    import sts_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [APB_ADDR_W-1:0] ADDR_COUNT  = {REG_ENTRY_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SIGNED = {REG_COMPARE_SIGNED, 2'b00};
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    typedef struct {
        bit             found;
        bit [POS_W-1:0] position;
    } t_search_result;

    class table_search_checker;
        bit [KEY_IN_W-1:0] keys [DEPTH];
        int                span;
        bit                cmp_signed;
        t_search_result    awaited_results [$];
        int                errors;
        int                results_checked;
        int                op_seen [4];

        function void set_count(bit [CNT_CFG_W-1:0] value);
            span = (value > DEPTH) ? DEPTH : int'(value);
        endfunction

        // order-preserving unsigned view of a key; self-inverse
        function bit [KEY_IN_W-1:0] rank(bit [KEY_IN_W-1:0] k);
            return cmp_signed ? (k ^ SIGN_BIT) : k;
        endfunction

        function t_search_result search_outcome(t_op op, bit [IDX_IN_W-1:0] idx,
                                                bit [KEY_IN_W-1:0] key);
            t_search_result    r;
            int                lo;
            int                hi;
            int                mid;
            bit [KEY_IN_W-1:0] k;
            bit [KEY_IN_W-1:0] probe;
            r.found    = 1'b0;
            r.position = '0;
            lo = 0;
            hi = span;
            k  = rank(key);
            case (op)
                OP_WRITE: begin
                    keys[idx]  = key;
                    r.position = POS_W'(idx);
                end
                OP_FIND: begin
                    while (lo < hi) begin
                        mid   = lo + (hi - lo) / 2;
                        probe = rank(keys[mid]);
                        if (k > probe) begin
                            lo = mid + 1;
                        end else if (k < probe) begin
                            hi = mid;
                        end else begin
                            r.found    = 1'b1;
                            r.position = POS_W'(mid);
                            lo = hi;
                        end
                    end
                end
                OP_LOWER: begin
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (k > rank(keys[mid])) lo = mid + 1;
                        else hi = mid;
                    end
                    r.position = POS_W'(lo);
                end
                default: begin
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (k >= rank(keys[mid])) lo = mid + 1;
                        else hi = mid;
                    end
                    r.position = POS_W'(hi);
                end
            endcase
            return r;
        endfunction

        function void note_request(t_op op, bit [IDX_IN_W-1:0] idx,
                                   bit [KEY_IN_W-1:0] key);
            op_seen[op]++;
            awaited_results.push_back(search_outcome(op, idx, key));
        endfunction

        function void check_result(bit found, bit [POS_W-1:0] position);
            t_search_result want;
            if (awaited_results.size() == 0) begin
                $error("result with no request pending: found %0d position %0d",
                       found, position);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, position);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation   = '0;
    logic [IDX_IN_W-1:0]   i_entry_index = '0;
    logic [KEY_IN_W-1:0]   i_key_value   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic                  o_found;
    logic [POS_W-1:0]      o_position;

    table_search_checker board;
    int mode;
    int issued;
    int cycles;
    int hold_left;
    bit hold_done;

    sorted_table_binary_search uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_entry_index(i_entry_index),
        .i_key_value  (i_key_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_position   (o_position)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (board != null && o_out_valid && !i_out_stall)
            board.check_result(o_found, o_position);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && board != null && board.results_checked >= 300) begin
            hold_done = 1'b1;
            hold_left = 200;
            i_out_stall <= 1'b1;
        end else begin
            case (mode)
                0:       i_out_stall <= ($urandom_range(99) < 45);
                1:       i_out_stall <= ($urandom_range(99) < 28);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(t_op op, bit [IDX_IN_W-1:0] idx, bit [KEY_IN_W-1:0] key);
        int gap_pct;
        gap_pct = (mode == 0) ? 28 : (mode == 1) ? 45 : 0;
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_key_value   <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(op, idx, key);
        issued++;
        mode = (issued < 600) ? 0 : (issued < 1200) ? 1 : 2;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(bit [CNT_CFG_W-1:0] count, bit sgn);
        reg_write(ADDR_COUNT, APB_DATA_W'(count));
        board.set_count(count);
        reg_write(ADDR_SIGNED, APB_DATA_W'(sgn));
        board.cmp_signed = sgn;
    endtask

    // writes entries 0..n-1 with keys non-decreasing in the chosen compare order
    task automatic load_sorted(int n, bit sgn);
        longint unsigned u;
        longint unsigned step_max;
        int              i;
        u        = $urandom_range(3);
        step_max = 2 * (64'hFFFF_FFFF / n);
        for (i = 0; i < n; i++) begin
            if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
            if (i == n - 1 && $urandom_range(1)) u = 64'hFFFF_FFFF;
            send_request(OP_WRITE, IDX_IN_W'(i), 32'(u) ^ (sgn ? SIGN_BIT : 32'h0));
            if ($urandom_range(99) >= 15) u += $urandom_range(32'(step_max), 1);
        end
        drain();
    endtask

    function automatic bit [KEY_IN_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (board.span != 0 && r < 50)
            return board.keys[$urandom_range(board.span - 1)];
        if (board.span != 0 && r < 70)
            return board.keys[$urandom_range(board.span - 1)]
                   + ($urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF);
        if (r < 80)
            return board.rank($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
        return $urandom;
    endfunction

    task automatic run_phase(bit [CNT_CFG_W-1:0] count, bit sgn, int n);
        int                i;
        bit [IDX_IN_W-1:0] idx;
        set_config(count, sgn);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8) begin
                idx = IDX_IN_W'($urandom_range(DEPTH - 1));
                send_request(OP_WRITE, idx,
                             ($urandom_range(99) < 70) ? board.keys[idx] : $urandom);
            end else begin
                send_request(t_op'($urandom_range(3, 1)), IDX_IN_W'($urandom), pick_key());
            end
        end
        drain();
    endtask

    initial begin
        board = new;
        mode  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, reset configuration written explicitly
        set_config(11'd0, 1'b0);
        send_request(OP_FIND,  10'd0, 32'h0000_0000);
        send_request(OP_LOWER, 10'd0, 32'h0000_0000);
        send_request(OP_UPPER, 10'd0, 32'h0000_0000);
        send_request(OP_FIND,  10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_LOWER, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_UPPER, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 10'd0, 32'h0000_0000);
        send_request(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 10'h155, 32'h5555_5555);
        send_request(OP_WRITE, 10'h2AA, 32'hAAAA_AAAA);
        drain();

        load_sorted(DEPTH, 1'b0);
        run_phase(11'd1024, 1'b0, 240);
        run_phase(11'h7FF, 1'b1, 90);
        load_sorted(64, 1'b1);
        run_phase(11'd64, 1'b1, 200);
        run_phase(11'd1, 1'b1, 40);
        load_sorted(9, 1'b0);
        run_phase(11'd9, 1'b0, 60);
        run_phase(11'd2, 1'b0, 30);

        repeat (40) @(posedge i_clk);
        $display("%0d requests: %0d writes, %0d finds, %0d lower, %0d upper bounds",
                 issued, board.op_seen[OP_WRITE], board.op_seen[OP_FIND],
                 board.op_seen[OP_LOWER], board.op_seen[OP_UPPER]);
        $display("%0d results checked over counts 0..2047, both compare modes, %0d cycles",
                 board.results_checked, cycles);
        if (board.errors == 0 && board.awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sts_pkg.sv
design/sts_ram.sv
design/sts_front.sv
design/sts_back.sv
design/sorted_table_binary_search.sv
bench/sorted_table_binary_search_tb.sv
